/* hw/rtl/scdc_pkg.sv */
// Shared types, constants and codes for the sidechain ducking compressor.
`default_nettype none

package scdc_pkg;

   // Default block length of the target glide; a power of two, so the glide divide is a shift
   localparam int BLOCK_SIZE_DEF = 256;

   // Q1.31 unity
   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

   // Request payload
   typedef struct packed {
      logic signed [15:0] in_l;
      logic signed [15:0] in_r;
      logic [31:0]        side_level_l;
      logic [31:0]        side_level_r;
      logic [31:0]        attack_l;
      logic [31:0]        attack_r;
      logic [31:0]        release_l;
      logic [31:0]        release_r;
   } req_type;

   // Result payload
   typedef struct packed {
      logic signed [15:0] out_l;
      logic signed [15:0] out_r;
      logic [31:0]        level_l;
      logic [31:0]        level_r;
   } rsp_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_MUL0,
      ST_T_MUL1,
      ST_T_ADD,
      ST_T_UPD,
      ST_C_MUL0,
      ST_C_MUL1,
      ST_C_ADD,
      ST_C_UPD,
      ST_O_MUL,
      ST_O_STORE,
      ST_FINISH
   } state_type;

   // Multiplier operand pairs
   typedef enum logic [2:0] {
      MUL_T_SPAN,    // target * (N - pos)
      MUL_SIDE_POS,  // side level * pos
      MUL_KEEP_C,    // (1 - k) * current
      MUL_K_T,       // k * target
      MUL_GAIN       // sample * (1 - current)
   } mul_sel_type;

   // Accumulator operations
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        capture;
      logic        ch;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        t_upd;
      logic        c_upd;
      logic        out_store;
      logic        rsp_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* hw/rtl/scdc_datapath.sv */
// Datapath: shared multiplier, accumulator, glide shift, level state and result register.
`default_nettype none

module scdc_datapath import scdc_pkg::*; #(
   parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_type       req_data,
   input  wire logic          rsp_ready,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int POS_W    = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int SPAN_W   = $clog2(BLOCK_SIZE + 1);
   localparam int GLIDE_SH = $clog2(BLOCK_SIZE);
   localparam int MUL_W    = 33;
   localparam int ACC_W    = 64;

   localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(BLOCK_SIZE - 1);
   localparam logic [SPAN_W-1:0] SPAN_FULL = SPAN_W'(BLOCK_SIZE);

   function automatic logic [31:0] sat_one(input logic [31:0] v);
      return (v > ONE_Q31) ? ONE_Q31 : v;
   endfunction

   // Captured request; levels and coefficients are saturated at unity on entry
   logic signed [15:0] smp_ff  [2];
   logic signed [15:0] smp_in  [2];
   logic [31:0]        side_ff [2];
   logic [31:0]        side_in [2];
   logic [31:0]        att_ff  [2];
   logic [31:0]        att_in  [2];
   logic [31:0]        rel_ff  [2];
   logic [31:0]        rel_in  [2];

   // Envelope state
   logic [31:0]        t_ff [2];
   logic [31:0]        t_in [2];
   logic [31:0]        c_ff [2];
   logic [31:0]        c_in [2];
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;

   // Arithmetic
   logic [ACC_W-1:0]   prod_ff;
   logic [ACC_W-1:0]   prod_in;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   acc_in;

   // Finished samples and result register
   logic signed [15:0] outw_ff [2];
   logic signed [15:0] outw_in [2];
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   logic [31:0]              t_cur;
   logic [31:0]              c_cur;
   logic [31:0]              k_sel;
   logic [SPAN_W-1:0]        span;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic [32:0]              c_wide;
   logic [31:0]              c_new;

   // Operands of the selected channel
   assign t_cur = t_ff[cmd.ch];
   assign c_cur = c_ff[cmd.ch];
   assign k_sel = (t_cur >= c_cur) ? att_ff[cmd.ch] : rel_ff[cmd.ch];
   assign span  = SPAN_FULL - SPAN_W'(pos_ff);

   // Shared multiplier operand mux
   always_comb begin
      case (cmd.mul_sel)
         MUL_T_SPAN: begin
            mul_a = {1'b0, t_cur};
            mul_b = MUL_W'(span);
         end
         MUL_SIDE_POS: begin
            mul_a = {1'b0, side_ff[cmd.ch]};
            mul_b = MUL_W'(pos_ff);
         end
         MUL_KEEP_C: begin
            mul_a = {1'b0, ONE_Q31 - k_sel};
            mul_b = {1'b0, c_cur};
         end
         MUL_K_T: begin
            mul_a = {1'b0, k_sel};
            mul_b = {1'b0, t_cur};
         end
         MUL_GAIN: begin
            mul_a = {{(MUL_W - 16){smp_ff[cmd.ch][15]}}, smp_ff[cmd.ch]};
            mul_b = {1'b0, ONE_Q31 - c_cur};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_p[ACC_W-1:0];

   // Accumulator
   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ff;
         ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   // New current level, clipped at unity
   assign c_wide = acc_ff[ACC_W-1:31];
   assign c_new  = (c_wide > {1'b0, ONE_Q31}) ? ONE_Q31 : c_wide[31:0];

   // Request capture, level state, finished samples
   always_comb begin
      smp_in  = smp_ff;
      side_in = side_ff;
      att_in  = att_ff;
      rel_in  = rel_ff;
      t_in    = t_ff;
      c_in    = c_ff;
      outw_in = outw_ff;
      if (cmd.capture) begin
         smp_in[0]  = req_data.in_l;
         smp_in[1]  = req_data.in_r;
         side_in[0] = sat_one(req_data.side_level_l);
         side_in[1] = sat_one(req_data.side_level_r);
         att_in[0]  = sat_one(req_data.attack_l);
         att_in[1]  = sat_one(req_data.attack_r);
         rel_in[0]  = sat_one(req_data.release_l);
         rel_in[1]  = sat_one(req_data.release_r);
      end
      if (cmd.t_upd) begin
         // weighted sum over the block length, which is a power of two
         t_in[cmd.ch] = sat_one(acc_ff[GLIDE_SH +: 32]);
      end
      if (cmd.c_upd) begin
         c_in[cmd.ch] = c_new;
      end
      if (cmd.out_store) begin
         // floor(sample * gain / 2^31)
         outw_in[cmd.ch] = prod_ff[46:31];
      end
   end

   // Block position and result register
   always_comb begin
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         pos_in         = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
         rsp_in.out_l   = outw_ff[0];
         rsp_in.out_r   = outw_ff[1];
         rsp_in.level_l = c_ff[0];
         rsp_in.level_r = c_ff[1];
         rsp_valid_in   = 1'b1;
      end
   end

   // State with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff         <= '{default: '0};
         c_ff         <= '{default: '0};
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         t_ff         <= t_in;
         c_ff         <= c_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      smp_ff  <= smp_in;
      side_ff <= side_in;
      att_ff  <= att_in;
      rel_ff  <= rel_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      outw_ff <= outw_in;
      rsp_ff  <= rsp_in;
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

/* hw/rtl/scdc_ctrl.sv */
// Controller: sequences the datapath through both channels of one request.
`default_nettype none

module scdc_ctrl import scdc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type             state_ff;
   state_type             state_in;
   logic                  ch_ff;
   logic                  ch_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_T_MUL0;
               ch_in    = 1'b0;
            end
         end
         ST_T_MUL0:   state_in = ST_T_MUL1;
         ST_T_MUL1:   state_in = ST_T_ADD;
         ST_T_ADD:    state_in = ST_T_UPD;
         ST_T_UPD:    state_in = ST_C_MUL0;
         ST_C_MUL0:   state_in = ST_C_MUL1;
         ST_C_MUL1:   state_in = ST_C_ADD;
         ST_C_ADD:    state_in = ST_C_UPD;
         ST_C_UPD:    state_in = ST_O_MUL;
         ST_O_MUL:    state_in = ST_O_STORE;
         ST_O_STORE: begin
            if (!ch_ff) begin
               ch_in    = 1'b1;
               state_in = ST_T_MUL0;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd         = '0;
      cmd.ch      = ch_ff;
      cmd.mul_sel = MUL_T_SPAN;
      cmd.acc_op  = ACC_HOLD;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // no request is taken while reset is held
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         ST_T_MUL0:   cmd.mul_sel = MUL_T_SPAN;
         ST_T_MUL1: begin
            cmd.mul_sel = MUL_SIDE_POS;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_T_ADD:    cmd.acc_op = ACC_ADD;
         ST_T_UPD:    cmd.t_upd = 1'b1;
         ST_C_MUL0:   cmd.mul_sel = MUL_KEEP_C;
         ST_C_MUL1: begin
            cmd.mul_sel = MUL_K_T;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_C_ADD:    cmd.acc_op = ACC_ADD;
         ST_C_UPD:    cmd.c_upd = 1'b1;
         ST_O_MUL:    cmd.mul_sel = MUL_GAIN;
         ST_O_STORE:  cmd.out_store = 1'b1;
         ST_FINISH:   cmd.rsp_load = status.rsp_free;
         default:     cmd.acc_op = ACC_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sidechain_ducking_compressor.sv */
// Stereo sidechain ducking compressor, top level.
//
// req_* carries one stereo sample with the block's sidechain levels and the
// attack and release coefficients of each channel; rsp_* returns the ducked
// samples and the envelope levels after the update, one result per request.
// Both channels are valid/ready.
// A request is taken only when the block is idle. Both channels are worked
// in turn through one shared 33x33 multiplier (five products per channel);
// the glide divide by the block length, a power of two, is a shift.
// The block takes the next request only once the result of the last one is
// loaded into the result register.
// The result register holds a finished result while the next request is
// worked; if the receiver stalls, the block waits in its final step until
// the register frees, then takes new requests again.
// Reset clears the target and current levels and the block position; the
// block is ready as soon as reset is released.
`default_nettype none

module sidechain_ducking_compressor import scdc_pkg::*; #(
   parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   scdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scdc_datapath #(
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Busy after every accepted request
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready
   ) else $error("request accepted while still ready");

   // A held result is never overwritten
   a_no_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.rsp_load
   ) else $error("result register loaded while stalled");

   // Reported levels stay within unity
   a_level_range: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.level_l <= ONE_Q31 && rsp_data.level_r <= ONE_Q31)
   ) else $error("envelope level above unity");

endmodule

`default_nettype wire
